[src/timetag_coincidence_histogrammer_defines.svh]
// assertion macros for the time-tag coincidence histogrammer
// used by the top level, expects clk and rst_n in scope
`ifndef TIMETAG_COINCIDENCE_HISTOGRAMMER_DEFINES_SVH
`define TIMETAG_COINCIDENCE_HISTOGRAMMER_DEFINES_SVH

// same-cycle implication
`define TCH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tch same-cycle check failed");

// next-cycle implication
`define TCH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tch next-cycle check failed");

`endif

[src/tch_pkg.sv]
// shared types and constants of the time-tag coincidence histogrammer
// no dependencies
package tch_pkg;

    // default sizes
    localparam int NUM_BINS_DEF   = 2048;
    localparam int COUNT_BITS_DEF = 32;

    // field widths
    localparam int TS_W    = 63;
    localparam int CH_W    = 7;
    localparam int RB_W    = 11;
    localparam int BW_W    = 10;
    localparam int DLY_W   = 16;
    localparam int GATE_W  = 11;
    localparam int START_W = 48;
    localparam int TOT_W   = 32;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;
    localparam int IN_W    = 88;
    localparam int OUT_W   = 224;

    // opcodes
    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    // register indexes
    localparam logic [IDX_W-1:0] REG_BIN_WIDTH = 3'd0;
    localparam logic [IDX_W-1:0] REG_REF_DELAY = 3'd1;
    localparam logic [IDX_W-1:0] REG_GATE_ST   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GATE_LEN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_CH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_REF_CH    = 3'd5;
    localparam logic [IDX_W-1:0] REG_TEST_CH   = 3'd6;

    // register reset values
    localparam logic [BW_W-1:0]   RST_BIN_WIDTH = 10'd10;
    localparam logic [DLY_W-1:0]  RST_REF_DELAY = 16'd4200;
    localparam logic [GATE_W-1:0] RST_GATE_ST   = 11'd500;
    localparam logic [GATE_W-1:0] RST_GATE_LEN  = 11'd800;
    localparam logic [CH_W-1:0]   RST_START_CH  = 7'd1;
    localparam logic [CH_W-1:0]   RST_REF_CH    = 7'd2;
    localparam logic [CH_W-1:0]   RST_TEST_CH   = 7'd3;

endpackage

[src/timetag_coincidence_histogrammer.sv]
// Time-tag coincidence histogrammer.
// Input stream s_*: one word per command. s_tuser carries the opcode
// (event, read bin, clear, no operation); s_tdata carries timestamp,
// channel and read bin. Output stream m_*: one result word per command,
// with hit flags, the bin counts read and the running totals.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register, cfg_data holds its value; always ready, write only while idle.
// An event runs through the bit-serial restoring divider (one quotient bit
// per cycle) and then through the sequencer states to its result word. A
// clear writes one histogram entry per cycle over all NUM_BINS entries,
// then reports zero totals.
// One command at a time: s_tready is high only while the sequencer waits.
// After reset the block sweeps all NUM_BINS entries of both histogram
// memories to zero before it first raises s_tready.
// The result sits in an output register; a new command is accepted while
// it waits, and a later result waits for the receiver before loading.
// Depends on tch_pkg and timetag_coincidence_histogrammer_defines.svh.
`include "timetag_coincidence_histogrammer_defines.svh"

module timetag_coincidence_histogrammer
    import tch_pkg::*;
#(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    // command stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,  // timestamp_ps, channel_number, read_bin
    input  logic [1:0]       s_tuser,  // opcode
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // in_window, event_bin, coincidence_hit, ref_bin_count, coin_bin_count,
    // start_total, test_total, ref_total, coin_total
    output logic [OUT_W-1:0] m_tdata
);

    localparam int BIN_BITS = $clog2(NUM_BINS);
    localparam int DIV_STEPS = TS_W;
    localparam int DCNT_W = $clog2(DIV_STEPS);
    localparam int SUB_W = TS_W + 2;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_DIV, ST_EV_START, ST_COIN_RD, ST_COIN_WR,
        ST_EV_REF, ST_REF_CHK, ST_REF_RD, ST_REF_WR, ST_EV_TEST,
        ST_RD_ADDR, ST_RD_DATA, ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [BW_W-1:0]   bin_width_reg;
    logic [DLY_W-1:0]  ref_delay_reg;
    logic [GATE_W-1:0] gate_st_reg;
    logic [GATE_W-1:0] gate_len_reg;
    logic [CH_W-1:0]   start_ch_reg;
    logic [CH_W-1:0]   ref_ch_reg;
    logic [CH_W-1:0]   test_ch_reg;

    // command registers
    logic [TS_W-1:0]     quo_reg;
    logic [BW_W-1:0]     rem_reg;
    logic [DCNT_W-1:0]   div_cnt_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [RB_W-1:0]     rb_reg;
    logic                clr_op_reg;
    logic [BIN_BITS-1:0] clr_cnt_reg;
    logic [SUB_W-1:0]    diff_reg;
    logic [BIN_BITS-1:0] bin_reg;

    // block state
    logic [TS_W-1:0]     period_start_reg;
    logic [BIN_BITS-1:0] pending_reg;
    logic                test_seen_reg;
    logic [START_W-1:0]  start_cnt_reg;
    logic [TOT_W-1:0]    test_cnt_reg;
    logic [TOT_W-1:0]    ref_sum_reg;
    logic [TOT_W-1:0]    coin_sum_reg;

    // per-command result fields
    logic                win_reg;
    logic [RB_W-1:0]     ebin_reg;
    logic                coin_reg;
    logic [TOT_W-1:0]    rcnt_reg;
    logic [TOT_W-1:0]    ccnt_reg;

    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    // histogram memories
    logic [COUNT_BITS-1:0] ref_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] coin_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] ref_q;
    logic [COUNT_BITS-1:0] coin_q;
    logic [BIN_BITS-1:0]   mem_addr;
    logic                  ref_we;
    logic                  coin_we;
    logic [COUNT_BITS-1:0] ref_wdata;
    logic [COUNT_BITS-1:0] coin_wdata;

    logic [BW_W-1:0]   divisor;
    logic [BW_W:0]     trial;
    logic [BW_W:0]     trial_sub;
    logic              qbit;
    logic [GATE_W:0]   gate_hi;
    logic              lo_ok;
    logic              hi_ok;
    logic              bin_ok;
    logic              accept;
    logic              out_free;
    logic [47:0]       ref_q_ext;
    logic [47:0]       coin_q_ext;

    function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // divider step, zero width acts as one
    assign divisor   = (bin_width_reg == '0) ? BW_W'(1) : bin_width_reg;
    assign trial     = {rem_reg, quo_reg[TS_W-1]};
    assign trial_sub = trial - {1'b0, divisor};
    assign qbit      = (trial >= {1'b0, divisor});

    // gate window checks on the signed offset
    assign gate_hi = {1'b0, gate_st_reg} + {1'b0, gate_len_reg};
    assign lo_ok   = !diff_reg[SUB_W-1] && (diff_reg > SUB_W'(gate_st_reg));
    assign hi_ok   = !diff_reg[SUB_W-1] && (diff_reg < SUB_W'(gate_hi));
    assign bin_ok  = (diff_reg <= SUB_W'(NUM_BINS));

    // clamp of stored counts to the reported width
    assign ref_q_ext  = 48'(ref_q);
    assign coin_q_ext = 48'(coin_q);

    // memory address and write control
    always_comb
    begin
        mem_addr   = bin_reg;
        ref_we     = 1'b0;
        coin_we    = 1'b0;
        ref_wdata  = sat_cnt(ref_q);
        coin_wdata = sat_cnt(coin_q);
        unique case (state_reg)
            ST_CLR:
            begin
                mem_addr   = clr_cnt_reg;
                ref_we     = 1'b1;
                coin_we    = 1'b1;
                ref_wdata  = '0;
                coin_wdata = '0;
            end
            ST_COIN_RD:  mem_addr = pending_reg;
            ST_COIN_WR:
            begin
                mem_addr = pending_reg;
                coin_we  = 1'b1;
            end
            ST_REF_WR:   ref_we = 1'b1;
            ST_RD_ADDR:  mem_addr = BIN_BITS'(rb_reg);
            default:     mem_addr = bin_reg;
        endcase
    end

    // reference histogram
    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[mem_addr] <= ref_wdata;
        end
        ref_q <= ref_mem[mem_addr];
    end

    // coincidence histogram
    always_ff @(posedge clk)
    begin
        if (coin_we)
        begin
            coin_mem[mem_addr] <= coin_wdata;
        end
        coin_q <= coin_mem[mem_addr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= RST_BIN_WIDTH;
            ref_delay_reg <= RST_REF_DELAY;
            gate_st_reg   <= RST_GATE_ST;
            gate_len_reg  <= RST_GATE_LEN;
            start_ch_reg  <= RST_START_CH;
            ref_ch_reg    <= RST_REF_CH;
            test_ch_reg   <= RST_TEST_CH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BIN_WIDTH: bin_width_reg <= cfg_data[BW_W-1:0];
                REG_REF_DELAY: ref_delay_reg <= cfg_data[DLY_W-1:0];
                REG_GATE_ST:   gate_st_reg   <= cfg_data[GATE_W-1:0];
                REG_GATE_LEN:  gate_len_reg  <= cfg_data[GATE_W-1:0];
                REG_START_CH:  start_ch_reg  <= cfg_data[CH_W-1:0];
                REG_REF_CH:    ref_ch_reg    <= cfg_data[CH_W-1:0];
                REG_TEST_CH:   test_ch_reg   <= cfg_data[CH_W-1:0];
                default:       ;
            endcase
        end
    end

    // sequencer, block state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLR;
            clr_cnt_reg      <= '0;
            clr_op_reg       <= 1'b0;
            period_start_reg <= '0;
            pending_reg      <= '0;
            test_seen_reg    <= 1'b0;
            start_cnt_reg    <= '0;
            test_cnt_reg     <= '0;
            ref_sum_reg      <= '0;
            coin_sum_reg     <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            div_cnt_reg      <= '0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            ch_reg           <= '0;
            rb_reg           <= '0;
            diff_reg         <= '0;
            bin_reg          <= '0;
            win_reg          <= 1'b0;
            ebin_reg         <= '0;
            coin_reg         <= 1'b0;
            rcnt_reg         <= '0;
            ccnt_reg         <= '0;
        end
        else
        begin
            // the finish state reloads the output itself
            if (out_valid_reg && m_tready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                // sweep both memories to zero
                ST_CLR:
                begin
                    if (clr_cnt_reg == BIN_BITS'(NUM_BINS - 1))
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= clr_op_reg ? ST_FINISH : ST_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                // take a command word
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        quo_reg     <= s_tdata[TS_W-1:0];
                        ch_reg      <= s_tdata[TS_W+CH_W-1:TS_W];
                        rb_reg      <= s_tdata[TS_W+CH_W+RB_W-1:TS_W+CH_W];
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        win_reg     <= 1'b0;
                        ebin_reg    <= '0;
                        coin_reg    <= 1'b0;
                        rcnt_reg    <= '0;
                        ccnt_reg    <= '0;
                        clr_op_reg  <= 1'b0;
                        unique case (opcode_t'(s_tuser))
                            OP_EVENT: state_reg <= ST_DIV;
                            OP_READ:  state_reg <= ST_RD_ADDR;
                            OP_CLEAR:
                            begin
                                clr_op_reg       <= 1'b1;
                                period_start_reg <= '0;
                                pending_reg      <= '0;
                                test_seen_reg    <= 1'b0;
                                start_cnt_reg    <= '0;
                                test_cnt_reg     <= '0;
                                ref_sum_reg      <= '0;
                                coin_sum_reg     <= '0;
                                state_reg        <= ST_CLR;
                            end
                            default:  state_reg <= ST_FINISH;
                        endcase
                    end
                end
                // one quotient bit per cycle
                ST_DIV:
                begin
                    rem_reg     <= qbit ? trial_sub[BW_W-1:0] : trial[BW_W-1:0];
                    quo_reg     <= {quo_reg[TS_W-2:0], qbit};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_EV_START;
                    end
                end
                // start role closes the period
                ST_EV_START:
                begin
                    if (ch_reg == start_ch_reg)
                    begin
                        if (!(&start_cnt_reg))
                        begin
                            start_cnt_reg <= start_cnt_reg + 1'b1;
                        end
                        period_start_reg <= quo_reg;
                        if (test_seen_reg && pending_reg != '0)
                        begin
                            state_reg <= ST_COIN_RD;
                        end
                        else
                        begin
                            test_seen_reg <= 1'b0;
                            pending_reg   <= '0;
                            state_reg     <= ST_EV_REF;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_EV_REF;
                    end
                end
                ST_COIN_RD:  state_reg <= ST_COIN_WR;
                ST_COIN_WR:
                begin
                    coin_sum_reg  <= sat_tot(coin_sum_reg);
                    coin_reg      <= 1'b1;
                    test_seen_reg <= 1'b0;
                    pending_reg   <= '0;
                    state_reg     <= ST_EV_REF;
                end
                // reference offset from period start and delay
                ST_EV_REF:
                begin
                    if (ch_reg == ref_ch_reg)
                    begin
                        diff_reg  <= {2'b00, quo_reg}
                                     - ({2'b00, period_start_reg} + SUB_W'(ref_delay_reg));
                        state_reg <= ST_REF_CHK;
                    end
                    else
                    begin
                        state_reg <= ST_EV_TEST;
                    end
                end
                ST_REF_CHK:
                begin
                    if (lo_ok && hi_ok && bin_ok)
                    begin
                        bin_reg     <= BIN_BITS'(diff_reg - 1'b1);
                        pending_reg <= BIN_BITS'(diff_reg - 1'b1);
                        state_reg   <= ST_REF_RD;
                    end
                    else
                    begin
                        pending_reg <= '0;
                        state_reg   <= ST_EV_TEST;
                    end
                end
                ST_REF_RD:   state_reg <= ST_REF_WR;
                ST_REF_WR:
                begin
                    ref_sum_reg <= sat_tot(ref_sum_reg);
                    win_reg     <= 1'b1;
                    ebin_reg    <= RB_W'(bin_reg);
                    state_reg   <= ST_EV_TEST;
                end
                // test role
                ST_EV_TEST:
                begin
                    if (ch_reg == test_ch_reg)
                    begin
                        test_seen_reg <= 1'b1;
                        test_cnt_reg  <= sat_tot(test_cnt_reg);
                    end
                    state_reg <= ST_FINISH;
                end
                // bin read
                ST_RD_ADDR:  state_reg <= ST_RD_DATA;
                ST_RD_DATA:
                begin
                    if (17'(rb_reg) < 17'(NUM_BINS))
                    begin
                        rcnt_reg <= (ref_q_ext > 48'hFFFF_FFFF) ? '1 : ref_q_ext[TOT_W-1:0];
                        ccnt_reg <= (coin_q_ext > 48'hFFFF_FFFF) ? '1 : coin_q_ext[TOT_W-1:0];
                    end
                    state_reg <= ST_FINISH;
                end
                // load the result word once the output is free
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {coin_sum_reg, ref_sum_reg, test_cnt_reg,
                                          start_cnt_reg, ccnt_reg, rcnt_reg,
                                          coin_reg, ebin_reg, win_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    `TCH_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
    `TCH_ASSERT_NEXT(a_result_loaded, state_reg == ST_FINISH && out_free, m_tvalid)
    `TCH_ASSERT_NOW(a_both_we_only_clear, ref_we && coin_we, state_reg == ST_CLR)
    `TCH_ASSERT_NOW(a_no_accept_when_busy, state_reg == ST_DIV, !s_tready)

endmodule

[tb/timetag_coincidence_histogrammer_test.sv]
// self-checking testbench of the time-tag coincidence histogrammer
// depends on tch_pkg and the timetag_coincidence_histogrammer top level
`timescale 1ns / 100ps

module timetag_coincidence_histogrammer_test;
    import tch_pkg::*;

    localparam int  BINS        = NUM_BINS_DEF;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  HOLD_CYCLES = 400;
    localparam int  SETTLE      = 120;
    localparam logic [TOT_W-1:0]   MAX32 = '1;
    localparam logic [START_W-1:0] MAX48 = '1;

    typedef struct {
        opcode_t           op;
        logic [TS_W-1:0]   ts;
        logic [CH_W-1:0]   ch;
        logic [RB_W-1:0]   rb;
    } command_t;

    typedef struct {
        logic               win;
        logic [RB_W-1:0]    ebin;
        logic               coin;
        logic [TOT_W-1:0]   rcnt;
        logic [TOT_W-1:0]   ccnt;
        logic [START_W-1:0] starts;
        logic [TOT_W-1:0]   tests;
        logic [TOT_W-1:0]   refs;
        logic [TOT_W-1:0]   coins;
    } tally_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // configuration copy
    logic [BW_W-1:0]   bin_width;
    logic [DLY_W-1:0]  ref_delay;
    logic [GATE_W-1:0] gate_st;
    logic [GATE_W-1:0] gate_len;
    logic [CH_W-1:0]   start_ch;
    logic [CH_W-1:0]   ref_ch;
    logic [CH_W-1:0]   test_ch;

    // histogram state copy
    logic [TS_W-1:0]    period_bin;
    logic [RB_W-1:0]    pending_bin;
    logic               test_flag;
    logic [TOT_W-1:0]   ref_hist [BINS];
    logic [TOT_W-1:0]   coin_hist [BINS];
    logic [START_W-1:0] start_count;
    logic [TOT_W-1:0]   test_count;
    logic [TOT_W-1:0]   ref_count;
    logic [TOT_W-1:0]   coin_count;

    command_t command_queue[$];
    command_t in_flight;
    tally_t   expected_tallies[$];
    int       errors = 0;
    int       words_in = 0;
    int       words_out = 0;
    int       gate_hits = 0;
    int       coin_hits = 0;
    int       cycles = 0;
    int       idle_pct = 16;
    bit       hold_go = 1'b0;
    bit       hold_done = 1'b0;
    int       hold_left = 0;

    timetag_coincidence_histogrammer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // timestamp_ps, channel_number, read_bin
        .s_tuser   (s_tuser),   // opcode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // in_window, event_bin, coincidence_hit, ref_bin_count, coin_bin_count,
        // start_total, test_total, ref_total, coin_total
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic clear_tallies();
        period_bin  = '0;
        pending_bin = '0;
        test_flag   = 1'b0;
        for (int i = 0; i < BINS; i++)
        begin
            ref_hist[i]  = '0;
            coin_hist[i] = '0;
        end
        start_count = '0;
        test_count  = '0;
        ref_count   = '0;
        coin_count  = '0;
    endtask

    // histogram update for one accepted command, queues the expected word
    task automatic histogram_step(command_t c);
        logic [TS_W-1:0] t;
        logic [63:0]     base;
        logic [63:0]     lo;
        logic [63:0]     hi;
        logic [63:0]     b;
        logic [TS_W-1:0] div;
        tally_t          r;
        r = '{default: '0};
        case (c.op)
            OP_EVENT:
            begin
                div = (bin_width == 0) ? 1 : TS_W'(bin_width);
                t = c.ts / div;
                if (c.ch == start_ch)
                begin
                    if (test_flag && pending_bin != 0)
                    begin
                        if (coin_hist[pending_bin] != MAX32)
                            coin_hist[pending_bin]++;
                        if (coin_count != MAX32)
                            coin_count++;
                        r.coin = 1'b1;
                    end
                    if (start_count != MAX48)
                        start_count++;
                    period_bin  = t;
                    test_flag   = 1'b0;
                    pending_bin = '0;
                end
                if (c.ch == ref_ch)
                begin
                    base = {1'b0, period_bin} + ref_delay;
                    lo   = base + gate_st;
                    hi   = lo + gate_len;
                    pending_bin = '0;
                    if (64'(t) > lo && 64'(t) < hi)
                    begin
                        b = 64'(t) - base - 1;
                        if (b < BINS)
                        begin
                            pending_bin = b[RB_W-1:0];
                            if (ref_hist[b] != MAX32)
                                ref_hist[b]++;
                            if (ref_count != MAX32)
                                ref_count++;
                            r.win  = 1'b1;
                            r.ebin = b[RB_W-1:0];
                        end
                    end
                end
                if (c.ch == test_ch)
                begin
                    test_flag = 1'b1;
                    if (test_count != MAX32)
                        test_count++;
                end
            end
            OP_READ:
            begin
                r.rcnt = ref_hist[c.rb];
                r.ccnt = coin_hist[c.rb];
            end
            OP_CLEAR: clear_tallies();
            default: ;
        endcase
        r.starts = start_count;
        r.tests  = test_count;
        r.refs   = ref_count;
        r.coins  = coin_count;
        expected_tallies.push_back(r);
    endtask

    // configuration copy follows accepted writes
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BIN_WIDTH: bin_width = cfg_data[BW_W-1:0];
                REG_REF_DELAY: ref_delay = cfg_data[DLY_W-1:0];
                REG_GATE_ST:   gate_st   = cfg_data[GATE_W-1:0];
                REG_GATE_LEN:  gate_len  = cfg_data[GATE_W-1:0];
                REG_START_CH:  start_ch  = cfg_data[CH_W-1:0];
                REG_REF_CH:    ref_ch    = cfg_data[CH_W-1:0];
                REG_TEST_CH:   test_ch   = cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                histogram_step(in_flight);
                words_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (command_queue.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_flight = command_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= in_flight.op;
                    s_tdata  <= IN_W'({in_flight.rb, in_flight.ch, in_flight.ts});
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %0d, actual %0d", name, exp, act);
            errors++;
        end
    endtask

    // long receiver hold-off, counted on its own
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        tally_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_out++;
                if (expected_tallies.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_tallies.pop_front();
                    gate_hits += e.win;
                    coin_hits += e.coin;
                    check_field("in_window", e.win, m_tdata[0]);
                    check_field("event_bin", e.ebin, m_tdata[11:1]);
                    check_field("coincidence_hit", e.coin, m_tdata[12]);
                    check_field("ref_bin_count", e.rcnt, m_tdata[44:13]);
                    check_field("coin_bin_count", e.ccnt, m_tdata[76:45]);
                    check_field("start_total", e.starts, m_tdata[124:77]);
                    check_field("test_total", e.tests, m_tdata[156:125]);
                    check_field("ref_total", e.refs, m_tdata[188:157]);
                    check_field("coin_total", e.coins, m_tdata[220:189]);
                end
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic push(opcode_t op, logic [TS_W-1:0] ts, logic [CH_W-1:0] ch,
                        logic [RB_W-1:0] rb);
        command_t c;
        c.op = op;
        c.ts = ts;
        c.ch = ch;
        c.rb = rb;
        command_queue.push_back(c);
    endtask

    // timestamp that lands in bin t for the current width
    function automatic logic [TS_W-1:0] ts_in_bin(logic [63:0] t);
        logic [63:0] w;
        w = (bin_width == 0) ? 1 : 64'(bin_width);
        return TS_W'(t * w + $urandom_range(int'(w) - 1));
    endfunction

    // starts the caller at a clock edge
    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(int bw, int dly, int gs, int gl, int sc, int rc, int tc);
        cfg_write(REG_BIN_WIDTH, CFG_W'(bw));
        cfg_write(REG_REF_DELAY, CFG_W'(dly));
        cfg_write(REG_GATE_ST, CFG_W'(gs));
        cfg_write(REG_GATE_LEN, CFG_W'(gl));
        cfg_write(REG_START_CH, CFG_W'(sc));
        cfg_write(REG_REF_CH, CFG_W'(rc));
        cfg_write(REG_TEST_CH, CFG_W'(tc));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until everything sent has come back and the block is quiet
    task automatic drain();
        @(posedge clk);
        while (command_queue.size() > 0 || s_tvalid || expected_tallies.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly well-formed periods with random content, plus noise
    task automatic random_commands(int count);
        int          pushed;
        int          sel;
        int          nref;
        logic [63:0] t0;
        logic [63:0] k;
        logic [63:0] w;
        logic [63:0] top;
        logic [RB_W-1:0] last_bin;
        pushed = 0;
        last_bin = '0;
        w = (bin_width == 0) ? 1 : 64'(bin_width);
        top = (64'h7FFF_FFFF_FFFF_FFFF / w) - 64'd200000;
        while (pushed < count)
        begin
            sel = $urandom_range(99);
            if (sel < 72)
            begin
                if ($urandom_range(9) == 0)
                    t0 = top - $urandom_range(100000);
                else
                    t0 = {$urandom, $urandom} & 64'h0000_00FF_FFFF_FFFF;
                push(OP_EVENT, ts_in_bin(t0), start_ch, RB_W'($urandom));
                pushed++;
                nref = $urandom_range(2);
                for (int i = 0; i < nref; i++)
                begin
                    case ($urandom_range(9))
                        0: k = gate_st;
                        1: k = 64'(gate_st) + gate_len;
                        2: k = 64'(gate_st) + 1;
                        3: k = $urandom_range(5000);
                        default: k = 64'(gate_st) + 1 +
                            $urandom_range((gate_len > 1) ? gate_len - 2 : 0);
                    endcase
                    last_bin = RB_W'(k - 1);
                    push(OP_EVENT, ts_in_bin(t0 + ref_delay + k), ref_ch, '0);
                    pushed++;
                    if ($urandom_range(99) < 55)
                    begin
                        push(OP_EVENT, ts_in_bin(t0 + $urandom_range(70000)), test_ch, '0);
                        pushed++;
                    end
                end
                if ($urandom_range(99) < 30)
                begin
                    push(OP_READ, TS_W'({$urandom, $urandom}), CH_W'($urandom), last_bin);
                    pushed++;
                end
            end
            else if (sel < 82)
            begin
                push(OP_READ, TS_W'({$urandom, $urandom}), CH_W'($urandom), RB_W'($urandom));
                pushed++;
            end
            else if (sel < 84)
            begin
                push(OP_CLEAR, TS_W'({$urandom, $urandom}), CH_W'($urandom), RB_W'($urandom));
                pushed++;
            end
            else if (sel < 88)
            begin
                push(OP_NOP, TS_W'({$urandom, $urandom}), CH_W'($urandom), RB_W'($urandom));
                pushed++;
            end
            else
            begin
                push(OP_EVENT, TS_W'({$urandom, $urandom}), CH_W'($urandom), RB_W'($urandom));
                pushed++;
            end
        end
    endtask

    initial
    begin
        bin_width = RST_BIN_WIDTH;
        ref_delay = RST_REF_DELAY;
        gate_st   = RST_GATE_ST;
        gate_len  = RST_GATE_LEN;
        start_ch  = RST_START_CH;
        ref_ch    = RST_REF_CH;
        test_ch   = RST_TEST_CH;
        clear_tallies();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset settings: gate edges, bin zero, coincidence
        push(OP_NOP, '0, '0, '0);
        push(OP_READ, '1, '1, '0);
        push(OP_READ, '0, '0, '1);
        push(OP_EVENT, '0, RST_START_CH, '0);
        push(OP_EVENT, TS_W'(47000), RST_REF_CH, '0);
        push(OP_EVENT, TS_W'(47019), RST_REF_CH, '0);
        push(OP_EVENT, TS_W'(47010), RST_REF_CH, '0);
        push(OP_EVENT, TS_W'(47000), RST_START_CH, '0);
        push(OP_EVENT, TS_W'(47000 + 47025), RST_REF_CH, '0);
        push(OP_EVENT, TS_W'(5), RST_TEST_CH, '0);
        push(OP_EVENT, TS_W'(0), RST_START_CH, '0);
        push(OP_EVENT, TS_W'(47020), RST_REF_CH, '0);
        push(OP_EVENT, TS_W'(12999), RST_TEST_CH, '0);
        push(OP_EVENT, TS_W'(99), RST_START_CH, '0);
        push(OP_EVENT, TS_W'(13000 + 47000 - 1), RST_REF_CH, '0);
        push(OP_EVENT, TS_W'(13000 + 47000), RST_REF_CH, '0);
        push(OP_READ, '0, '0, 11'd1);
        push(OP_EVENT, '1, 7'h7F, '1);
        push(OP_EVENT, '1, RST_START_CH, '0);
        push(OP_EVENT, '1, RST_REF_CH, '0);
        push(OP_CLEAR, '0, '0, '0);
        push(OP_READ, '0, '0, 11'd1);
        drain();

        // receiver stalls for a long stretch while commands keep coming
        hold_go = 1'b1;
        random_commands(300);
        drain();

        // no idling, smallest width and delay, start and reference shared
        idle_pct = 0;
        configure(1, 0, 0, 2047, 9, 9, 127);
        random_commands(300);
        drain();
        idle_pct = 16;

        // largest delay, gate and start channel, wide bins, gate runs past the store
        configure(1000, 65535, 2047, 2047, 127, 0, 0);
        random_commands(300);
        drain();

        // zero width acts as one, narrowest gate, all roles on one channel
        configure(0, 3, 0, 1, 5, 5, 5);
        random_commands(220);
        drain();

        // narrow gate with only one accepted offset, test shares start
        configure(3, 100, 10, 2, 64, 65, 64);
        random_commands(220);
        drain();

        // middle settings, reference and test shared
        configure(37, 1234, 300, 1500, 42, 85, 85);
        random_commands(300);
        drain();

        $display("covered %0d commands, %0d result words, %0d gated hits, %0d coincidences",
                 words_in, words_out, gate_hits, coin_hits);
        $display("over six register settings, with stalls, a long hold-off and clears");
        if (errors == 0 && expected_tallies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
